// File: rtl/sha1e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 hash engine package
// Shared types, constants and the command/status bundle between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sha1e_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned LenWidthDefault = 64;
  localparam int unsigned DigestWords     = 5;
  localparam logic [2:0]  LastWordIdx     = 3'd4;

  localparam word_t HashInit [DigestWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t RoundK [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  // byte source for the block buffer write port
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_MARK = 2'd1,
    SRC_ZERO = 2'd2
  } sha1e_src_e;

  typedef struct packed {
    logic       byte_wr;     // write one byte at the current position
    sha1e_src_e byte_src;
    logic       count_inc;   // add one byte to the bit count
    logic       len_wr;      // write the length into the last two words
    logic       hash_load;   // load a..e from the chaining words
    logic       round_en;    // run one compression round
    logic [1:0] round_stage; // which group of twenty rounds
    logic       chain_add;   // fold a..e into the chaining words
    logic       chain_init;  // restart: initial hash, zero counts
    logic       out_load;    // load one digest word into the output register
    logic [2:0] out_idx;
  } sha1e_cmd_t;

  typedef struct packed {
    logic [5:0] pos;       // byte position within the block
    logic       out_free;  // output register can take a word this cycle
  } sha1e_sts_t;

endpackage
`default_nettype wire

// File: rtl/sha1e_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Block buffer with rolling schedule window, round logic, chaining words,
// length counter and the digest output register.
// ----------------------------------------------------------------------------
module sha1e_dp #(
  parameter int unsigned LenWidth = sha1e_pkg::LenWidthDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire sha1e_pkg::sha1e_cmd_t  cmd_i,
  output sha1e_pkg::sha1e_sts_t       sts_o,
  input  wire logic [7:0]             in_byte_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [31:0]                 out_word_o,
  output logic [2:0]                  out_idx_o,
  output logic                        out_last_o
);
  import sha1e_pkg::*;

  logic [5:0]          pos_q;
  logic [LenWidth-1:0] count_q;
  word_t               win_q [16];
  word_t               a_q, b_q, c_q, d_q, e_q;
  word_t               chain_q [DigestWords];
  logic                out_valid_q;
  word_t               out_word_q;
  logic [2:0]          out_idx_q;
  logic                out_last_q;

  logic [7:0]  byte_val;
  logic [4:0]  lane_sh;
  logic [63:0] len_field;
  word_t       f_val;
  word_t       w_next;
  word_t       t_val;

  always_comb begin
    case (cmd_i.byte_src)
      SRC_DATA: byte_val = in_byte_i;
      SRC_MARK: byte_val = 8'h80;
      default:  byte_val = 8'h00;
    endcase
  end

  // big-endian lane: byte 0 of a word lands in bits 31:24
  assign lane_sh   = {~pos_q[1:0], 3'b000};
  assign len_field = 64'(count_q);

  always_comb begin
    case (cmd_i.round_stage)
      2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
      2'd2:    f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      default: f_val = b_q ^ c_q ^ d_q;
    endcase
  end

  assign w_next = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign t_val  = {a_q[26:0], a_q[31:27]} + f_val + e_q + win_q[0]
                + RoundK[cmd_i.round_stage];

  // block buffer and schedule window
  always_ff @(posedge clk_i) begin
    if (cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= {w_next[30:0], w_next[31]};
    end else if (cmd_i.len_wr) begin
      win_q[14] <= len_field[63:32];
      win_q[15] <= len_field[31:0];
    end else if (cmd_i.byte_wr) begin
      win_q[pos_q[5:2]][lane_sh +: 8] <= byte_val;
    end
  end

  // working variables
  always_ff @(posedge clk_i) begin
    if (cmd_i.hash_load) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (cmd_i.round_en) begin
      a_q <= t_val;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      count_q <= '0;
      for (int i = 0; i < DigestWords; i++) begin
        chain_q[i] <= HashInit[i];
      end
    end else begin
      if (cmd_i.chain_init) begin
        pos_q   <= '0;
        count_q <= '0;
        for (int i = 0; i < DigestWords; i++) begin
          chain_q[i] <= HashInit[i];
        end
      end else begin
        if (cmd_i.byte_wr) begin
          pos_q <= pos_q + 6'd1;
        end
        if (cmd_i.count_inc) begin
          count_q <= count_q + LenWidth'(8);
        end
        if (cmd_i.chain_add) begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
          chain_q[4] <= chain_q[4] + e_q;
        end
      end
    end
  end

  // output register: hold the beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_word_q <= chain_q[cmd_i.out_idx];
      out_idx_q  <= cmd_i.out_idx;
      out_last_q <= (cmd_i.out_idx == LastWordIdx);
    end
  end

  assign sts_o.pos      = pos_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_idx_o   = out_idx_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

// File: rtl/sha1e_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, padding, the 80-round compression and the digest
// readout by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module sha1e_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_present_i,
  input  wire logic                   in_last_i,
  output logic                        in_ready_o,
  input  wire sha1e_pkg::sha1e_sts_t  sts_i,
  output sha1e_pkg::sha1e_cmd_t       cmd_o
);
  import sha1e_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MARK  = 3'd1;
  localparam logic [2:0] S_ZERO  = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_ADD   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  // where to go once a block is compressed
  localparam logic [1:0] RET_IDLE = 2'd0;
  localparam logic [1:0] RET_MARK = 2'd1;
  localparam logic [1:0] RET_ZERO = 2'd2;
  localparam logic [1:0] RET_EMIT = 2'd3;

  localparam logic [5:0] PosLast   = 6'd63;
  localparam logic [5:0] PosLen    = 6'd56;
  localparam logic [6:0] RoundLast = 7'd79;
  localparam logic [6:0] Stage1    = 7'd20;
  localparam logic [6:0] Stage2    = 7'd40;
  localparam logic [6:0] Stage3    = 7'd60;

  logic [2:0] state_q, state_d;
  logic [1:0] ret_q, ret_d;
  logic       len_ok_q, len_ok_d;
  logic [6:0] round_q, round_d;
  logic [2:0] word_q, word_d;
  logic [1:0] stage;

  always_comb begin
    if (round_q < Stage1) begin
      stage = 2'd0;
    end else if (round_q < Stage2) begin
      stage = 2'd1;
    end else if (round_q < Stage3) begin
      stage = 2'd2;
    end else begin
      stage = 2'd3;
    end
  end

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    len_ok_d = len_ok_q;
    round_d  = round_q;
    word_d   = word_q;
    cmd_o    = '0;
    cmd_o.byte_src    = SRC_DATA;
    cmd_o.round_stage = stage;
    cmd_o.out_idx     = word_q;
    in_ready_o        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.byte_wr   = in_present_i;
          cmd_o.count_inc = in_present_i;
          if (in_present_i && sts_i.pos == PosLast) begin
            state_d = S_LOAD;
            ret_d   = in_last_i ? RET_MARK : RET_IDLE;
          end else if (in_last_i) begin
            state_d = S_MARK;
          end
        end
      end
      S_MARK: begin
        cmd_o.byte_wr  = 1'b1;
        cmd_o.byte_src = SRC_MARK;
        if (sts_i.pos == PosLast) begin
          state_d  = S_LOAD;
          ret_d    = RET_ZERO;
          len_ok_d = 1'b1;
        end else begin
          state_d  = S_ZERO;
          len_ok_d = (sts_i.pos < PosLen);
        end
      end
      S_ZERO: begin
        if (len_ok_q && sts_i.pos == PosLen) begin
          state_d = S_LEN;
        end else begin
          cmd_o.byte_wr  = 1'b1;
          cmd_o.byte_src = SRC_ZERO;
          // no room for the length: finish this block, pad a fresh one
          if (sts_i.pos == PosLast) begin
            state_d  = S_LOAD;
            ret_d    = RET_ZERO;
            len_ok_d = 1'b1;
          end
        end
      end
      S_LEN: begin
        cmd_o.len_wr = 1'b1;
        state_d      = S_LOAD;
        ret_d        = RET_EMIT;
      end
      S_LOAD: begin
        cmd_o.hash_load = 1'b1;
        round_d         = '0;
        state_d         = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round_en = 1'b1;
        if (round_q == RoundLast) begin
          state_d = S_ADD;
        end else begin
          round_d = round_q + 7'd1;
        end
      end
      S_ADD: begin
        cmd_o.chain_add = 1'b1;
        word_d          = '0;
        case (ret_q)
          RET_IDLE: state_d = S_IDLE;
          RET_MARK: state_d = S_MARK;
          RET_ZERO: state_d = S_ZERO;
          default:  state_d = S_EMIT;
        endcase
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (word_q == LastWordIdx) begin
            cmd_o.chain_init = 1'b1;
            state_d          = S_IDLE;
          end else begin
            word_d = word_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= RET_IDLE;
      len_ok_q <= 1'b0;
      round_q  <= '0;
      word_q   <= '0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      len_ok_q <= len_ok_d;
      round_q  <= round_d;
      word_q   <= word_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/sha1_hash_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Hashes a byte stream and returns the five digest words after each message.
//
//   channel   dir  tdata               tuser             tlast
//   s_axis    in   message byte        byte present      end of message
//   m_axis    out  digest word         word number 0..4  fifth word
//
// A byte beat is taken while the controller is idle; every 64th byte triggers a
// compression (load, 80 rounds through one round unit, chain update).
// End of message pads one byte per cycle, pausing while a full block compresses,
// runs one or two more blocks and then loads one digest word per cycle as the
// output register frees up. Reset restores the initial hash and clears the
// counts; the output register holds a beat until m_axis_tready_i takes it.
// ----------------------------------------------------------------------------
module sha1_hash_engine_top #(
  parameter int unsigned LenWidth = sha1e_pkg::LenWidthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] byte_present
  input  wire logic        s_axis_tlast_i,   // end_of_message
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser_o,   // [2:0] word_number
  output logic             m_axis_tlast_o    // last_word
);
  import sha1e_pkg::*;

  sha1e_cmd_t cmd;
  sha1e_sts_t sts;

  sha1e_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_present_i(s_axis_tuser_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sha1e_dp #(
    .LenWidth(LenWidth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_byte_i  (s_axis_tdata_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_word_o (m_axis_tdata_o),
    .out_idx_o  (m_axis_tuser_o),
    .out_last_o (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  a_no_intake_in_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.round_en |-> !s_axis_tready_o)
    else $error("input ready while compression rounds run");

  a_no_output_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("digest word loaded over a pending beat");

  a_data_write_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.byte_wr && cmd.byte_src == SRC_DATA) |-> (s_axis_tvalid_i && s_axis_tready_o))
    else $error("message byte written without an input beat");

  a_last_is_word4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tuser_o == LastWordIdx))
    else $error("last flag on a word other than the fifth");
`endif

endmodule
`default_nettype wire
